// ===== rtl/bmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter package
// Sizes, register codes and the words passed between the filter's parts.
// ----------------------------------------------------------------------------
package bmf_pkg;

	// Limits of the window and of the row.
	localparam int MAX_RADIUS = 15;
	localparam int MAX_WIDTH  = 2048;

	// Ring of rows kept in the row store.
	localparam int SLOTS = 2 * MAX_RADIUS + 1;

	localparam int PIXB = 8;
	localparam int RB   = $clog2(MAX_RADIUS + 1);
	localparam int WB   = 12;
	localparam int HB   = 12;
	localparam int XB   = $clog2(MAX_WIDTH);
	localparam int YB   = $clog2(4095 + MAX_RADIUS + 2);
	localparam int SB   = $clog2(SLOTS);
	localparam int CB   = $clog2(SLOTS + 1);
	localparam int CSB  = $clog2(SLOTS * 255 + 1);
	localparam int WSB  = $clog2(SLOTS * SLOTS * 255 + 1);
	localparam int CNB  = $clog2(SLOTS * SLOTS + 1);
	localparam int NUMB = $clog2(2 * SLOTS * SLOTS * 255 + SLOTS * SLOTS + 1);
	localparam int QB   = 8;

	// Configuration port.
	localparam int CIB = 3;
	localparam int CDB = 12;

	localparam logic [CIB-1:0] CFG_RADIUS = 3'd0;
	localparam logic [CIB-1:0] CFG_WIDTH  = 3'd1;
	localparam logic [CIB-1:0] CFG_HEIGHT = 3'd2;
	localparam logic [CIB-1:0] CFG_MODE   = 3'd3;

	// Effective frame geometry.
	typedef struct packed {
		logic [RB-1:0] r;
		logic [WB-1:0] w;
		logic [HB-1:0] h;
		logic          mode;
	} bmf_cfg_t;

	// One classified item from the front to the back.
	typedef struct packed {
		logic            is_pix;
		logic [PIXB-1:0] pix;
		logic [XB-1:0]   x;
		logic [SB-1:0]   slot;
		logic            first_row;
		logic            sub_old;
		logic            use_t;
		logic            out_en;
		logic [XB-1:0]   oj;
		logic [SB-1:0]   oslot;
		logic            border;
		logic [CB-1:0]   rows;
		logic [CB-1:0]   cols;
		logic            last;
	} bmf_item_t;

	// One result word.
	typedef struct packed {
		logic [PIXB-1:0] mean;
		logic            last;
	} bmf_result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SUM,
		ST_PREP,
		ST_DIV,
		ST_PUSH
	} bmf_state_t;

endpackage

// ===== rtl/bmf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter queue
// Small first-in first-out buffer of registers.
// ----------------------------------------------------------------------------
module bmf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PB = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PB-1:0]    wr_ptr_q;
	logic [PB-1:0]    rd_ptr_q;
	logic [PB:0]      count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == (PB+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (!do_push && do_pop) count_q <= count_q - 1'b1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== rtl/bmf_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter configuration
// Holds the registers and derives the effective frame geometry.
// ----------------------------------------------------------------------------
module bmf_cfg import bmf_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [CIB-1:0] cfg_index,
	input  logic [CDB-1:0] cfg_data,
	output bmf_cfg_t       cfg,
	output logic           restart
);

	logic [RB-1:0] radius_q;
	logic [WB-1:0] width_q;
	logic [HB-1:0] height_q;
	logic          mode_q;
	logic [WB-1:0] w1;
	logic [WB-1:0] w_eff;
	logic [WB-1:0] half;
	logic [RB-1:0] rad_c;

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid & cfg_ready;

	// Register writes; any write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RB'(1);
			width_q  <= WB'(640);
			height_q <= HB'(480);
			mode_q   <= 1'b0;
		end else if (restart) begin
			case (cfg_index)
				CFG_RADIUS: radius_q <= cfg_data[RB-1:0];
				CFG_WIDTH:  width_q  <= cfg_data[WB-1:0];
				CFG_HEIGHT: height_q <= cfg_data[HB-1:0];
				CFG_MODE:   mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Zero sizes count as one, the width saturates and the radius fits the row.
	always_comb begin
		w1    = (width_q == '0) ? WB'(1) : width_q;
		w_eff = (w1 > WB'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : w1;
		half  = (w_eff - 1'b1) >> 1;
		rad_c = (radius_q > RB'(MAX_RADIUS)) ? RB'(MAX_RADIUS) : radius_q;
		cfg.w = w_eff;
		cfg.h = (height_q == '0) ? HB'(1) : height_q;
		cfg.r = (WB'(rad_c) > half) ? half[RB-1:0] : rad_c;
		cfg.mode = mode_q;
	end

endmodule

// ===== rtl/bmf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter front
// Accepts words, tracks input and output positions and classifies each word.
// ----------------------------------------------------------------------------
module bmf_front import bmf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  bmf_cfg_t        cfg,
	input  logic            restart,
	input  logic            push,
	input  logic            action,
	input  logic [PIXB-1:0] pixel,
	input  logic            q_full,
	output logic            q_push,
	output bmf_item_t       q_item
);

	logic [XB-1:0] x_q;
	logic [YB-1:0] y_q;
	logic [SB-1:0] slot_q;
	logic [HB-1:0] oi_q;
	logic [XB-1:0] oj_q;
	logic [SB-1:0] oslot_q;

	logic          accept;
	logic          is_pix;
	logic          take;
	logic [SB-1:0] two_r;
	logic          x_end;
	logic          oj_end;
	logic [HB:0]   r1sum;
	logic [HB:0]   r1;
	logic [HB-1:0] r0;
	logic [WB-1:0] c1sum;
	logic [WB-1:0] c1;
	logic [WB-1:0] c0;

	assign accept = push & ~q_full;
	assign is_pix = (y_q < YB'(cfg.h));
	// A drain word before the frame is complete is dropped.
	assign take   = accept & ~(action & is_pix);
	assign q_push = take;
	assign two_r  = {cfg.r, 1'b0};
	assign x_end  = (WB'(x_q) == cfg.w - 1'b1);
	assign oj_end = (WB'(oj_q) == cfg.w - 1'b1);

	// Classification of the word and geometry of the window it completes.
	always_comb begin
		r0    = (oi_q >= HB'(cfg.r)) ? oi_q - HB'(cfg.r) : '0;
		r1sum = {1'b0, oi_q} + (HB+1)'(cfg.r);
		r1    = (r1sum < (HB+1)'(cfg.h)) ? r1sum : (HB+1)'(cfg.h) - 1'b1;
		c0    = (oj_q >= XB'(cfg.r)) ? WB'(oj_q - XB'(cfg.r)) : '0;
		c1sum = WB'(oj_q) + WB'(cfg.r);
		c1    = (c1sum < cfg.w) ? c1sum : cfg.w - 1'b1;

		q_item.is_pix    = is_pix;
		q_item.pix       = pixel;
		q_item.x         = x_q;
		q_item.slot      = slot_q;
		q_item.first_row = (y_q == '0);
		q_item.sub_old   = (y_q > YB'(two_r));
		q_item.use_t     = (x_q < XB'(cfg.r));
		q_item.out_en    = (y_q > YB'(cfg.r)) ||
			((y_q == YB'(cfg.r)) && (x_q >= XB'(cfg.r)));
		q_item.oj        = oj_q;
		q_item.oslot     = oslot_q;
		q_item.border    = cfg.mode & ((oi_q < HB'(cfg.r)) |
			(r1sum >= (HB+1)'(cfg.h)) | (oj_q < XB'(cfg.r)) | (c1sum >= cfg.w));
		q_item.rows      = CB'(r1 - {1'b0, r0} + 1'b1);
		q_item.cols      = CB'(c1 - c0 + 1'b1);
		q_item.last      = (oi_q == cfg.h - 1'b1) && oj_end;
	end

	// Position counters; they return to zero on a restart and after the last output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			slot_q  <= '0;
			oi_q    <= '0;
			oj_q    <= '0;
			oslot_q <= '0;
		end else if (restart || (take && q_item.out_en && q_item.last)) begin
			x_q     <= '0;
			y_q     <= '0;
			slot_q  <= '0;
			oi_q    <= '0;
			oj_q    <= '0;
			oslot_q <= '0;
		end else if (take) begin
			if (x_end) begin
				x_q    <= '0;
				y_q    <= y_q + 1'b1;
				slot_q <= (slot_q == two_r) ? '0 : slot_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
			if (q_item.out_en) begin
				if (oj_end) begin
					oj_q    <= '0;
					oi_q    <= oi_q + 1'b1;
					oslot_q <= (oslot_q == two_r) ? '0 : oslot_q + 1'b1;
				end else begin
					oj_q <= oj_q + 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/bmf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter back
// Keeps the row store and running sums and divides each window sum.
// ----------------------------------------------------------------------------
module bmf_back import bmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  bmf_cfg_t    cfg,
	input  bmf_item_t   item,
	input  logic        item_valid,
	output logic        item_pop,
	input  logic        res_full,
	output logic        res_push,
	output bmf_result_t res_data
);

	localparam int STORE_DEPTH = SLOTS * MAX_WIDTH;
	localparam int AB = $clog2(STORE_DEPTH);

	bmf_state_t state_q;
	bmf_state_t state_d;

	logic [PIXB-1:0] store_mem [STORE_DEPTH];
	logic [CSB-1:0]  col_mem [MAX_WIDTH];
	logic [CSB-1:0]  dly_q [SLOTS];

	bmf_item_t       item_q;
	logic [PIXB-1:0] old_q;
	logic [PIXB-1:0] copy_q;
	logic [CSB-1:0]  col_q;
	logic [WSB-1:0]  s_q;
	logic [WSB-1:0]  t_q;
	logic [WSB-1:0]  wsum_q;
	logic [NUMB-1:0] rem_q;
	logic [NUMB-1:0] den_q;
	logic [QB-1:0]   quot_q;
	logic [2:0]      step_q;

	logic [AB-1:0]   a_old;
	logic [AB-1:0]   a_copy;
	logic [CSB-1:0]  v;
	logic [CSB-1:0]  tap;
	logic [WSB-1:0]  s_new;
	logic [WSB-1:0]  t_new;
	logic [CNB-1:0]  cnt;
	logic            ge;

	// Row store is a ring of rows; the column index fills the low bits.
	assign a_old  = AB'({item_q.slot, item_q.x});
	assign a_copy = AB'({item_q.oslot, item_q.oj});
	assign tap    = dly_q[{cfg.r, 1'b0}];

	// New column sum, then the horizontal sums of this row and of the row before.
	always_comb begin
		v = (item_q.first_row ? '0 : col_q)
			+ (item_q.is_pix ? CSB'(item_q.pix) : '0)
			- (item_q.sub_old ? CSB'(old_q) : '0);
		s_new = ((item_q.x == '0) ? '0 : s_q) + WSB'(v)
			- ((item_q.x > XB'({cfg.r, 1'b0})) ? WSB'(tap) : '0);
		t_new = ((item_q.x == '0) ? s_q : t_q) - WSB'(tap);
		cnt   = CNB'(item_q.rows) * CNB'(item_q.cols);
		ge    = (rem_q >= den_q);
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Next state and handshakes.
	always_comb begin
		state_d  = state_q;
		item_pop = 1'b0;
		res_push = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: state_d = ST_SUM;
			ST_SUM: state_d = item_q.out_en ? ST_PREP : ST_IDLE;
			ST_PREP: state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == 3'd7) state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign res_data.mean = item_q.border ? copy_q : quot_q;
	assign res_data.last = item_q.last;

	// Row store: two reads, one write on the following cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			old_q  <= store_mem[a_old];
			copy_q <= store_mem[a_copy];
		end
		if (state_q == ST_SUM && item_q.is_pix) store_mem[a_old] <= item_q.pix;
	end

	// Column sums.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) col_q <= col_mem[item_q.x];
		if (state_q == ST_SUM) col_mem[item_q.x] <= v;
	end

	// Item latch, delay line of column sums, running sums and divider.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && item_valid) item_q <= item;
		if (state_q == ST_SUM) begin
			dly_q[0] <= v;
			for (int k = 1; k < SLOTS; k++) dly_q[k] <= dly_q[k-1];
			s_q    <= s_new;
			t_q    <= t_new;
			wsum_q <= item_q.use_t ? t_new : s_new;
		end
		if (state_q == ST_PREP) begin
			rem_q  <= NUMB'({wsum_q, 1'b0}) + NUMB'(cnt);
			den_q  <= NUMB'({cnt, 1'b0}) << (QB - 1);
			step_q <= '0;
		end
		if (state_q == ST_DIV) begin
			rem_q  <= ge ? rem_q - den_q : rem_q;
			quot_q <= {quot_q[QB-2:0], ge};
			den_q  <= den_q >> 1;
			step_q <= step_q + 1'b1;
		end
	end

endmodule

// ===== rtl/box_mean_filter_8bit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box mean filter, 8-bit grey
// Rounded mean over a square window, clipped or with copied borders.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// input     in         push / full          action, pixel
// result    out        empty / pop          mean_value, frame_last
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A word with a result passes the back sequencer's steps in order (pop, read,
// sum, prepare, eight divide steps, push); a word without one ends after sum.
// The back pops no new word until it is through with the last one.
// The row store has no reset; column sums are restarted on the first row.
// The front queues up to four words and stalls only when that queue is full.
// ----------------------------------------------------------------------------
module box_mean_filter_8bit import bmf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic            action,
	input  logic [PIXB-1:0] pixel,
	output logic            empty,
	input  logic            pop,
	output logic [PIXB-1:0] mean_value,
	output logic            frame_last,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [CIB-1:0]  cfg_index,
	input  logic [CDB-1:0]  cfg_data
);

	bmf_cfg_t    cfg;
	logic        restart;
	logic        q_push;
	bmf_item_t   q_item;
	bmf_item_t   head;
	logic        q_empty;
	logic        q_pop;
	logic        res_push;
	logic        res_full;
	bmf_result_t res_data;
	bmf_result_t res_head;

	// Configuration registers.
	bmf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.restart   (restart)
	);

	// Front: accept and classify.
	bmf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.restart (restart),
		.push    (push),
		.action  (action),
		.pixel   (pixel),
		.q_full  (full),
		.q_push  (q_push),
		.q_item  (q_item)
	);

	// Queue between front and back.
	bmf_queue #(
		.WIDTH ($bits(bmf_item_t)),
		.DEPTH (4)
	) u_item_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_item),
		.full    (full),
		.pop     (q_pop),
		.rd_data (head),
		.empty   (q_empty)
	);

	// Back: sums and division.
	bmf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item       (head),
		.item_valid (~q_empty),
		.item_pop   (q_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_data   (res_data)
	);

	// Result queue.
	bmf_queue #(
		.WIDTH ($bits(bmf_result_t)),
		.DEPTH (2)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.wr_data (res_data),
		.full    (res_full),
		.pop     (pop),
		.rd_data (res_head),
		.empty   (empty)
	);

	assign mean_value = res_head.mean;
	assign frame_last = res_head.last;

endmodule
